/* hdl/rept_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rept_pkg - shared types and constants for the rotary encoder tracker
// Register indexes, configuration bundle and reset values.
// ---------------------------------------------------------------------------
package rept_pkg;

	// default widths for the top-level parameters
	localparam int REPT_POSITION_BITS = 16;
	localparam int REPT_TIME_BITS     = 32;

	// configuration port index width
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_POSITION  = 3'd0,
		REG_MAX_POSITION  = 3'd1,
		REG_STEP_NORMAL   = 3'd2,
		REG_STEP_FAST     = 3'd3,
		REG_WRAP_ENABLE   = 3'd4,
		REG_DETENT_TMO    = 3'd5,
		REG_FAST_WINDOW   = 3'd6
	} rept_reg_idx_t;

	// register reset values
	localparam logic [7:0]  STEP_NORMAL_RST    = 8'd1;
	localparam logic [7:0]  STEP_FAST_RST      = 8'd1;
	localparam logic        WRAP_ENABLE_RST    = 1'b0;
	localparam logic [15:0] DETENT_TMO_RST     = 16'd2500;
	localparam logic [15:0] FAST_WINDOW_RST    = 16'd300;

	// fixed-width step and timing settings
	typedef struct packed {
		logic [7:0]  step_normal;
		logic [7:0]  step_fast;
		logic        wrap_enable;
		logic [15:0] detent_timeout_ms;
		logic [15:0] fast_window_ms;
	} rept_cfg_t;

endpackage

/* hdl/rept_cfg_regs.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rept_cfg_regs - configuration register file
// Write-only registers loaded from the plain write port.
// ---------------------------------------------------------------------------
module rept_cfg_regs
	import rept_pkg::*;
#(
	parameter int POSITION_BITS = REPT_POSITION_BITS,
	parameter int CFG_W         = (POSITION_BITS > 16) ? POSITION_BITS : 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [CFG_IDX_W-1:0]            cfg_index,
	input  logic [CFG_W-1:0]                cfg_wdata,
	output logic signed [POSITION_BITS-1:0] min_position,
	output logic signed [POSITION_BITS-1:0] max_position,
	output rept_cfg_t                       cfg
);

	// reset limits: one above the lowest code, one below the highest
	localparam logic [POSITION_BITS-1:0] MIN_RST =
		{1'b1, {(POSITION_BITS-2){1'b0}}, 1'b1};
	localparam logic [POSITION_BITS-1:0] MAX_RST =
		{1'b0, {(POSITION_BITS-2){1'b1}}, 1'b0};

	logic [POSITION_BITS-1:0] min_q;
	logic [POSITION_BITS-1:0] max_q;
	rept_cfg_t                cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q                   <= MIN_RST;
			max_q                   <= MAX_RST;
			cfg_q.step_normal       <= STEP_NORMAL_RST;
			cfg_q.step_fast         <= STEP_FAST_RST;
			cfg_q.wrap_enable       <= WRAP_ENABLE_RST;
			cfg_q.detent_timeout_ms <= DETENT_TMO_RST;
			cfg_q.fast_window_ms    <= FAST_WINDOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_POSITION: min_q                   <= cfg_wdata[POSITION_BITS-1:0];
				REG_MAX_POSITION: max_q                   <= cfg_wdata[POSITION_BITS-1:0];
				REG_STEP_NORMAL:  cfg_q.step_normal       <= cfg_wdata[7:0];
				REG_STEP_FAST:    cfg_q.step_fast         <= cfg_wdata[7:0];
				REG_WRAP_ENABLE:  cfg_q.wrap_enable       <= cfg_wdata[0];
				REG_DETENT_TMO:   cfg_q.detent_timeout_ms <= cfg_wdata[15:0];
				REG_FAST_WINDOW:  cfg_q.fast_window_ms    <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign min_position = $signed(min_q);
	assign max_position = $signed(max_q);
	assign cfg          = cfg_q;

endmodule

/* hdl/rept_step_logic.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rept_step_logic - next-state logic for one item
// Arms on A falling, steps on A rising, clamps or wraps, loads writes.
// ---------------------------------------------------------------------------
module rept_step_logic
	import rept_pkg::*;
#(
	parameter int POSITION_BITS = REPT_POSITION_BITS,
	parameter int TIME_BITS     = REPT_TIME_BITS
) (
	// item
	input  logic                            mode,
	input  logic                            a_level,
	input  logic                            b_level,
	input  logic [TIME_BITS-1:0]            now_ms,
	input  logic signed [POSITION_BITS-1:0] new_position,
	// settings
	input  logic signed [POSITION_BITS-1:0] min_position,
	input  logic signed [POSITION_BITS-1:0] max_position,
	input  rept_cfg_t                       cfg,
	// current state
	input  logic signed [POSITION_BITS-1:0] cur_pos,
	input  logic [TIME_BITS-1:0]            press_time,
	input  logic                            press_pending,
	input  logic                            dir_down,
	input  logic [TIME_BITS-1:0]            last_step_time,
	// next state
	output logic signed [POSITION_BITS-1:0] cur_pos_n,
	output logic [TIME_BITS-1:0]            press_time_n,
	output logic                            press_pending_n,
	output logic                            dir_down_n,
	output logic [TIME_BITS-1:0]            last_step_time_n,
	// result flags
	output logic                            stepped,
	output logic                            write_accepted
);

	// two guard bits hold any position plus or minus an 8-bit step
	localparam int WW = POSITION_BITS + 2;

	logic [TIME_BITS-1:0]     held;
	logic [TIME_BITS-1:0]     since_last;
	logic [TIME_BITS-1:0]     tmo;
	logic [TIME_BITS-1:0]     fast_win;
	logic [7:0]               inc;
	logic signed [WW-1:0]     cur_w;
	logic signed [WW-1:0]     min_w;
	logic signed [WW-1:0]     max_w;
	logic signed [WW-1:0]     inc_w;
	logic signed [WW-1:0]     moved;
	logic signed [WW-1:0]     upper_chk;
	logic signed [WW-1:0]     lower_chk;
	logic signed [POSITION_BITS-1:0] step_pos;
	logic                     write_ok;

	// elapsed times, modulo the timestamp width
	assign held       = now_ms - press_time;
	assign since_last = now_ms - last_step_time;
	assign tmo        = TIME_BITS'(cfg.detent_timeout_ms);
	assign fast_win   = TIME_BITS'(cfg.fast_window_ms);

	// step size and wide move
	assign inc   = (since_last < fast_win) ? cfg.step_fast : cfg.step_normal;
	assign cur_w = WW'(cur_pos);
	assign min_w = WW'(min_position);
	assign max_w = WW'(max_position);
	assign inc_w = $signed(WW'(inc));
	assign moved = dir_down ? (cur_w - inc_w) : (cur_w + inc_w);

	// upper check first, lower check on its result
	assign upper_chk = (moved > max_w) ? (cfg.wrap_enable ? min_w : max_w) : moved;
	assign lower_chk = (upper_chk < min_w) ? (cfg.wrap_enable ? max_w : min_w) : upper_chk;
	assign step_pos  = lower_chk[POSITION_BITS-1:0];

	assign write_ok = (new_position >= min_position) && (new_position <= max_position);

	// per-item decision
	always_comb begin
		cur_pos_n        = cur_pos;
		press_time_n     = press_time;
		press_pending_n  = press_pending;
		dir_down_n       = dir_down;
		last_step_time_n = last_step_time;
		stepped          = 1'b0;
		write_accepted   = 1'b0;
		if (mode) begin
			if (write_ok) begin
				cur_pos_n      = new_position;
				write_accepted = 1'b1;
			end
		end else if (!a_level) begin
			// falling A: arm, or re-arm once the old press has expired
			if (!press_pending || (held > tmo)) begin
				press_time_n    = now_ms;
				press_pending_n = 1'b1;
				dir_down_n      = b_level;
			end
		end else if (press_pending) begin
			// rising A: step if within the timeout, always disarm
			if (held < tmo) begin
				last_step_time_n = now_ms;
				cur_pos_n        = step_pos;
				stepped          = (step_pos != cur_pos);
			end
			press_pending_n = 1'b0;
			press_time_n    = '0;
		end
	end

endmodule

/* hdl/rotary_encoder_position_tracker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rotary_encoder_position_tracker - encoder position with acceleration
// Tracks a detent position from channel-A edge events and position writes.
// ---------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_stall  | mode, a_level, b_level, now_ms, new_position
//  out     | out_valid/out_stall| position, stepped, write_accepted
//  cfg     | cfg_we             | cfg_index, cfg_wdata
//
// One item per cycle while the output is not stalled.
// Items land in an input register; the step logic then updates the tracker
// state and the result register once the result register can take the item.
// A stalled result holds the pipe; the input register still takes an item
// while the result register is full, as long as it is itself empty. Reset
// clears the tracker state and reloads the register defaults.
// ---------------------------------------------------------------------------
module rotary_encoder_position_tracker
	import rept_pkg::*;
#(
	parameter int POSITION_BITS = REPT_POSITION_BITS,
	parameter int TIME_BITS     = REPT_TIME_BITS,
	parameter int CFG_W         = (POSITION_BITS > 16) ? POSITION_BITS : 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            mode,
	input  logic                            a_level,
	input  logic                            b_level,
	input  logic [TIME_BITS-1:0]            now_ms,
	input  logic signed [POSITION_BITS-1:0] new_position,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [POSITION_BITS-1:0] position,
	output logic                            stepped,
	output logic                            write_accepted,
	// configuration
	input  logic                            cfg_we,
	input  logic [CFG_IDX_W-1:0]            cfg_index,
	input  logic [CFG_W-1:0]                cfg_wdata
);

	logic signed [POSITION_BITS-1:0] min_position;
	logic signed [POSITION_BITS-1:0] max_position;
	rept_cfg_t                       cfg;

	// input register
	logic                            valid_s1;
	logic                            mode_s1;
	logic                            a_level_s1;
	logic                            b_level_s1;
	logic [TIME_BITS-1:0]            now_ms_s1;
	logic signed [POSITION_BITS-1:0] new_position_s1;

	// tracker state
	logic signed [POSITION_BITS-1:0] cur_pos_q;
	logic [TIME_BITS-1:0]            press_time_q;
	logic                            press_pending_q;
	logic                            dir_down_q;
	logic [TIME_BITS-1:0]            last_step_time_q;

	logic signed [POSITION_BITS-1:0] cur_pos_n;
	logic [TIME_BITS-1:0]            press_time_n;
	logic                            press_pending_n;
	logic                            dir_down_n;
	logic [TIME_BITS-1:0]            last_step_time_n;
	logic                            stepped_n;
	logic                            write_accepted_n;

	// result register
	logic                            out_valid_q;
	logic signed [POSITION_BITS-1:0] position_q;
	logic                            stepped_q;
	logic                            write_accepted_q;

	logic                            in_fire;
	logic                            s1_fire;

	rept_cfg_regs #(
		.POSITION_BITS (POSITION_BITS),
		.CFG_W         (CFG_W)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.min_position (min_position),
		.max_position (max_position),
		.cfg          (cfg)
	);

	// flow control: stage 1 moves when the result register frees up
	assign s1_fire  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_fire;
	assign in_fire  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_s1         <= mode;
			a_level_s1      <= a_level;
			b_level_s1      <= b_level;
			now_ms_s1       <= now_ms;
			new_position_s1 <= new_position;
		end
	end

	rept_step_logic #(
		.POSITION_BITS (POSITION_BITS),
		.TIME_BITS     (TIME_BITS)
	) u_step (
		.mode             (mode_s1),
		.a_level          (a_level_s1),
		.b_level          (b_level_s1),
		.now_ms           (now_ms_s1),
		.new_position     (new_position_s1),
		.min_position     (min_position),
		.max_position     (max_position),
		.cfg              (cfg),
		.cur_pos          (cur_pos_q),
		.press_time       (press_time_q),
		.press_pending    (press_pending_q),
		.dir_down         (dir_down_q),
		.last_step_time   (last_step_time_q),
		.cur_pos_n        (cur_pos_n),
		.press_time_n     (press_time_n),
		.press_pending_n  (press_pending_n),
		.dir_down_n       (dir_down_n),
		.last_step_time_n (last_step_time_n),
		.stepped          (stepped_n),
		.write_accepted   (write_accepted_n)
	);

	// tracker state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_pos_q        <= '0;
			press_time_q     <= '0;
			press_pending_q  <= 1'b0;
			dir_down_q       <= 1'b0;
			last_step_time_q <= '0;
		end else if (s1_fire) begin
			cur_pos_q        <= cur_pos_n;
			press_time_q     <= press_time_n;
			press_pending_q  <= press_pending_n;
			dir_down_q       <= dir_down_n;
			last_step_time_q <= last_step_time_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			position_q       <= cur_pos_n;
			stepped_q        <= stepped_n;
			write_accepted_q <= write_accepted_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign position       = position_q;
	assign stepped        = stepped_q;
	assign write_accepted = write_accepted_q;

	// a result never reports both a step and an accepted write
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(stepped && write_accepted))
		else $error("stepped and write_accepted both set");

	// an accepted write always lies inside the limits
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && write_accepted) |->
			((position >= min_position) && (position <= max_position)))
		else $error("accepted write outside limits");

	// a rising A edge event always leaves the tracker disarmed
	a_rise_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && !mode_s1 && a_level_s1) |=> !press_pending_q)
		else $error("press still pending after rising edge");

	// the reported position follows the tracker state
	a_pos_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> (position == cur_pos_q))
		else $error("result position differs from state");

	// stall is raised only while the input register holds an item
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked item");

endmodule
